### src/rtcfd_pkg.sv
// Shared types, constants and helper functions for the time code frame decoder.
package rtcfd_pkg;

  // Field widths
  localparam int PULSE_W   = 12;
  localparam int CENTER_W  = 12;
  localparam int MASK_W    = 60;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 60;
  localparam int SYM_W     = 2;
  localparam int SLOT_W    = 6;
  localparam int WEIGHT_W  = 8;
  localparam int PROD_W    = 10;
  localparam int MIN_W     = 8;
  localparam int HOUR_W    = 8;
  localparam int YDAY_W    = 11;
  localparam int YEAR_W    = 9;
  localparam int DST_W     = 4;

  // Default depth of the request queue between classifier and frame tracker
  localparam int QUEUE_DEPTH = 2;

  // Symbol codes
  localparam logic [SYM_W-1:0] SYM_ZERO   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_ONE    = 2'd1;
  localparam logic [SYM_W-1:0] SYM_MARKER = 2'd2;
  localparam logic [SYM_W-1:0] SYM_ERROR  = 2'd3;

  // Frame positions
  localparam logic [SLOT_W-1:0] SLOT_FIRST     = 6'd0;
  localparam logic [SLOT_W-1:0] SLOT_MIN_TENS  = 6'd1;
  localparam logic [SLOT_W-1:0] SLOT_LEAP_YEAR = 6'd55;
  localparam logic [SLOT_W-1:0] SLOT_LEAPSEC   = 6'd56;
  localparam logic [SLOT_W-1:0] SLOT_LAST      = 6'd59;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_CENTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_CENTER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER_CENTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MARGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_MASK   = 3'd4;

  // Configuration reset values
  localparam logic [CENTER_W-1:0] ZERO_CENTER_RST   = 12'd200;
  localparam logic [CENTER_W-1:0] ONE_CENTER_RST    = 12'd500;
  localparam logic [CENTER_W-1:0] MARKER_CENTER_RST = 12'd800;
  localparam logic [CENTER_W-1:0] WINDOW_MARGIN_RST = 12'd100;

  // Accumulator a data slot feeds
  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_MIN,
    TGT_HOUR,
    TGT_YDAY,
    TGT_YEAR,
    TGT_DST
  } target_t;

  typedef struct packed {
    target_t               target;
    logic [WEIGHT_W-1:0]   weight;
  } slot_weight_t;

  // Classifier to queue: one classified request
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
  } sym_req_t;

  // Queue status back to the classifier
  typedef struct packed {
    logic ready;
  } queue_stat_t;

  // Open window test: center - margin < pulse < center + margin, signed
  function automatic logic in_window(input logic [PULSE_W-1:0] pulse,
                                     input logic [CENTER_W-1:0] center,
                                     input logic [CENTER_W-1:0] margin);
    logic signed [CENTER_W+1:0] p;
    logic signed [CENTER_W+1:0] lo;
    logic signed [CENTER_W+1:0] hi;
    p  = $signed({2'b00, pulse});
    lo = $signed({2'b00, center}) - $signed({2'b00, margin});
    hi = $signed({2'b00, center}) + $signed({2'b00, margin});
    return (p > lo) && (p < hi);
  endfunction

  // Marker positions of the frame
  function automatic logic is_marker_slot(input logic [SLOT_W-1:0] s);
    return (s == 6'd0) || (s == 6'd9) || (s == 6'd19) || (s == 6'd29) ||
           (s == 6'd39) || (s == 6'd49) || (s == SLOT_LAST);
  endfunction

  // BCD weight table of the data slots
  function automatic slot_weight_t slot_weight(input logic [SLOT_W-1:0] s);
    slot_weight_t r;
    r.target = TGT_NONE;
    r.weight = '0;
    unique case (s)
      6'd1:  begin r.target = TGT_MIN;  r.weight = 8'd40;  end
      6'd2:  begin r.target = TGT_MIN;  r.weight = 8'd20;  end
      6'd3:  begin r.target = TGT_MIN;  r.weight = 8'd10;  end
      6'd5:  begin r.target = TGT_MIN;  r.weight = 8'd8;   end
      6'd6:  begin r.target = TGT_MIN;  r.weight = 8'd4;   end
      6'd7:  begin r.target = TGT_MIN;  r.weight = 8'd2;   end
      6'd8:  begin r.target = TGT_MIN;  r.weight = 8'd1;   end
      6'd12: begin r.target = TGT_HOUR; r.weight = 8'd20;  end
      6'd13: begin r.target = TGT_HOUR; r.weight = 8'd10;  end
      6'd15: begin r.target = TGT_HOUR; r.weight = 8'd8;   end
      6'd16: begin r.target = TGT_HOUR; r.weight = 8'd4;   end
      6'd17: begin r.target = TGT_HOUR; r.weight = 8'd2;   end
      6'd18: begin r.target = TGT_HOUR; r.weight = 8'd1;   end
      6'd22: begin r.target = TGT_YDAY; r.weight = 8'd200; end
      6'd23: begin r.target = TGT_YDAY; r.weight = 8'd100; end
      6'd25: begin r.target = TGT_YDAY; r.weight = 8'd80;  end
      6'd26: begin r.target = TGT_YDAY; r.weight = 8'd40;  end
      6'd27: begin r.target = TGT_YDAY; r.weight = 8'd20;  end
      6'd28: begin r.target = TGT_YDAY; r.weight = 8'd10;  end
      6'd30: begin r.target = TGT_YDAY; r.weight = 8'd8;   end
      6'd31: begin r.target = TGT_YDAY; r.weight = 8'd4;   end
      6'd32: begin r.target = TGT_YDAY; r.weight = 8'd2;   end
      6'd33: begin r.target = TGT_YDAY; r.weight = 8'd1;   end
      6'd45: begin r.target = TGT_YEAR; r.weight = 8'd80;  end
      6'd46: begin r.target = TGT_YEAR; r.weight = 8'd40;  end
      6'd47: begin r.target = TGT_YEAR; r.weight = 8'd20;  end
      6'd48: begin r.target = TGT_YEAR; r.weight = 8'd10;  end
      6'd50: begin r.target = TGT_YEAR; r.weight = 8'd8;   end
      6'd51: begin r.target = TGT_YEAR; r.weight = 8'd4;   end
      6'd52: begin r.target = TGT_YEAR; r.weight = 8'd2;   end
      6'd53: begin r.target = TGT_YEAR; r.weight = 8'd1;   end
      6'd57: begin r.target = TGT_DST;  r.weight = 8'd2;   end
      6'd58: begin r.target = TGT_DST;  r.weight = 8'd1;   end
      default: begin r.target = TGT_NONE; r.weight = '0;   end
    endcase
    return r;
  endfunction

endpackage

### src/rtcfd_if.sv
// Valid/ready channel interfaces for pulse requests and decoded results.
interface rtcfd_pulse_if;
  logic                             valid;
  logic                             ready;
  logic [rtcfd_pkg::PULSE_W-1:0]    pulse_ms;

  modport source (output valid, output pulse_ms, input ready);
  modport sink   (input valid, input pulse_ms, output ready);
endinterface

interface rtcfd_result_if;
  logic                             valid;
  logic                             ready;
  logic [rtcfd_pkg::SYM_W-1:0]      symbol;
  logic                             frame_done;
  logic [rtcfd_pkg::SLOT_W-1:0]     slot_next;
  logic [rtcfd_pkg::MIN_W-1:0]      minutes_acc;
  logic [rtcfd_pkg::HOUR_W-1:0]     hours_acc;
  logic [rtcfd_pkg::YDAY_W-1:0]     yearday_acc;
  logic [rtcfd_pkg::YEAR_W-1:0]     year_acc;
  logic [rtcfd_pkg::SYM_W-1:0]      leap_year_code;
  logic [rtcfd_pkg::SYM_W-1:0]      leapsec_code;
  logic [rtcfd_pkg::DST_W-1:0]      dst_acc;

  modport source (output valid, output symbol, output frame_done, output slot_next,
                  output minutes_acc, output hours_acc, output yearday_acc,
                  output year_acc, output leap_year_code, output leapsec_code,
                  output dst_acc, input ready);
  modport sink   (input valid, input symbol, input frame_done, input slot_next,
                  input minutes_acc, input hours_acc, input yearday_acc,
                  input year_acc, input leap_year_code, input leapsec_code,
                  input dst_acc, output ready);
endinterface

### src/rtcfd_classifier.sv
// Front end: configuration registers and pulse length classification.
module rtcfd_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [rtcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtcfd_pkg::CFG_DATA_W-1:0]    cfg_data,
  rtcfd_pulse_if.sink                         pulse_in,
  input  rtcfd_pkg::queue_stat_t              q_stat,
  output rtcfd_pkg::sym_req_t                 push,
  output logic [rtcfd_pkg::MASK_W-1:0]        ignore_error_mask
);

  logic [rtcfd_pkg::CENTER_W-1:0] zero_center_ms;
  logic [rtcfd_pkg::CENTER_W-1:0] one_center_ms;
  logic [rtcfd_pkg::CENTER_W-1:0] marker_center_ms;
  logic [rtcfd_pkg::CENTER_W-1:0] window_margin_ms;
  logic [rtcfd_pkg::SYM_W-1:0]    symbol;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_center_ms    <= rtcfd_pkg::ZERO_CENTER_RST;
      one_center_ms     <= rtcfd_pkg::ONE_CENTER_RST;
      marker_center_ms  <= rtcfd_pkg::MARKER_CENTER_RST;
      window_margin_ms  <= rtcfd_pkg::WINDOW_MARGIN_RST;
      ignore_error_mask <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rtcfd_pkg::CFG_ZERO_CENTER:
          zero_center_ms <= cfg_data[rtcfd_pkg::CENTER_W-1:0];
        rtcfd_pkg::CFG_ONE_CENTER:
          one_center_ms <= cfg_data[rtcfd_pkg::CENTER_W-1:0];
        rtcfd_pkg::CFG_MARKER_CENTER:
          marker_center_ms <= cfg_data[rtcfd_pkg::CENTER_W-1:0];
        rtcfd_pkg::CFG_WINDOW_MARGIN:
          window_margin_ms <= cfg_data[rtcfd_pkg::CENTER_W-1:0];
        rtcfd_pkg::CFG_IGNORE_MASK:
          ignore_error_mask <= cfg_data[rtcfd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Window tests, first match wins: zero, one, marker
  always_comb begin
    priority if (rtcfd_pkg::in_window(pulse_in.pulse_ms, zero_center_ms,
                                      window_margin_ms)) begin
      symbol = rtcfd_pkg::SYM_ZERO;
    end else if (rtcfd_pkg::in_window(pulse_in.pulse_ms, one_center_ms,
                                      window_margin_ms)) begin
      symbol = rtcfd_pkg::SYM_ONE;
    end else if (rtcfd_pkg::in_window(pulse_in.pulse_ms, marker_center_ms,
                                      window_margin_ms)) begin
      symbol = rtcfd_pkg::SYM_MARKER;
    end else begin
      symbol = rtcfd_pkg::SYM_ERROR;
    end
  end

  // Push straight into the queue; ready follows queue space
  assign pulse_in.ready = q_stat.ready;
  assign push.valid     = pulse_in.valid;
  assign push.symbol    = symbol;

endmodule

### src/rtcfd_queue.sv
// Short symbol queue between the classifier and the frame tracker.
module rtcfd_queue #(
  parameter int QUEUE_DEPTH = rtcfd_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  rtcfd_pkg::sym_req_t     push,
  output rtcfd_pkg::queue_stat_t  q_stat,
  output rtcfd_pkg::sym_req_t     head,
  input  logic                    pop
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [rtcfd_pkg::SYM_W-1:0] entries [QUEUE_DEPTH];
  logic [AW-1:0]               wr_ptr;
  logic [AW-1:0]               rd_ptr;
  logic [CW-1:0]               count;
  logic                        full;
  logic                        empty;
  logic                        do_push;
  logic                        do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && !empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.symbol;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign q_stat.ready = !full;
  assign head.valid   = !empty;
  assign head.symbol  = entries[rd_ptr];

`ifndef SYNTHESIS
  // Fill count stays within the storage
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // A push into a non-full queue is reflected in the count unless popped
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

### src/rtcfd_frame_tracker.sv
// Back end: slot tracking, resync rules, accumulators and result register.
module rtcfd_frame_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  rtcfd_pkg::sym_req_t              head,
  output logic                             pop,
  input  logic [rtcfd_pkg::MASK_W-1:0]     ignore_error_mask,
  rtcfd_result_if.source                   result_out
);

  // Frame state
  logic [rtcfd_pkg::SLOT_W-1:0] slot;
  logic [rtcfd_pkg::SYM_W-1:0]  prev_symbol;
  logic [rtcfd_pkg::MIN_W-1:0]  minutes_reg;
  logic [rtcfd_pkg::HOUR_W-1:0] hours_reg;
  logic [rtcfd_pkg::YDAY_W-1:0] yearday_reg;
  logic [rtcfd_pkg::YEAR_W-1:0] year_reg;
  logic [rtcfd_pkg::SYM_W-1:0]  leap_year_reg;
  logic [rtcfd_pkg::SYM_W-1:0]  leapsec_reg;
  logic [rtcfd_pkg::DST_W-1:0]  dst_reg;

  logic [rtcfd_pkg::SLOT_W-1:0] slot_next;
  logic [rtcfd_pkg::MIN_W-1:0]  minutes_next;
  logic [rtcfd_pkg::HOUR_W-1:0] hours_next;
  logic [rtcfd_pkg::YDAY_W-1:0] yearday_next;
  logic [rtcfd_pkg::YEAR_W-1:0] year_next;
  logic [rtcfd_pkg::SYM_W-1:0]  leap_year_next;
  logic [rtcfd_pkg::SYM_W-1:0]  leapsec_next;
  logic [rtcfd_pkg::DST_W-1:0]  dst_next;
  logic                         done_next;

  // Result register
  logic                         out_valid;
  logic [rtcfd_pkg::SYM_W-1:0]  out_symbol;
  logic                         out_done;
  logic [rtcfd_pkg::SLOT_W-1:0] out_slot;
  logic [rtcfd_pkg::MIN_W-1:0]  out_minutes;
  logic [rtcfd_pkg::HOUR_W-1:0] out_hours;
  logic [rtcfd_pkg::YDAY_W-1:0] out_yearday;
  logic [rtcfd_pkg::YEAR_W-1:0] out_year;
  logic [rtcfd_pkg::SYM_W-1:0]  out_leap_year;
  logic [rtcfd_pkg::SYM_W-1:0]  out_leapsec;
  logic [rtcfd_pkg::DST_W-1:0]  out_dst;

  // Working signals of the update
  logic [rtcfd_pkg::SYM_W-1:0]  sym;
  logic [rtcfd_pkg::SLOT_W-1:0] slot_rolled;
  logic [rtcfd_pkg::SLOT_W-1:0] slot_cur;
  logic [63:0]                  mask_ext;
  logic                         rollover;
  logic                         err_resync;
  logic                         dbl_marker;
  logic                         clear_early;
  rtcfd_pkg::slot_weight_t      sw;
  logic [rtcfd_pkg::PROD_W-1:0] prod;
  logic                         fire;

  // Take a request whenever the result register is free or being drained
  assign fire = head.valid && (!out_valid || result_out.ready);
  assign pop  = fire;

  assign sym         = head.symbol;
  assign rollover    = (slot > rtcfd_pkg::SLOT_LAST);
  assign slot_rolled = rollover ? rtcfd_pkg::SLOT_FIRST : slot;
  assign mask_ext    = {{(64 - rtcfd_pkg::MASK_W){1'b0}}, ignore_error_mask};
  assign err_resync  = (sym == rtcfd_pkg::SYM_ERROR) && !mask_ext[slot_rolled];
  assign dbl_marker  = (sym == rtcfd_pkg::SYM_MARKER) &&
                       (prev_symbol == rtcfd_pkg::SYM_MARKER);
  assign slot_cur    = dbl_marker ? rtcfd_pkg::SLOT_FIRST : slot_rolled;
  assign clear_early = rollover || dbl_marker;
  assign sw          = rtcfd_pkg::slot_weight(slot_cur);
  assign prod        = rtcfd_pkg::PROD_W'(sw.weight) * rtcfd_pkg::PROD_W'(sym);

  // Next frame state for one symbol
  always_comb begin
    done_next      = 1'b0;
    minutes_next   = clear_early ? '0 : minutes_reg;
    hours_next     = clear_early ? '0 : hours_reg;
    yearday_next   = clear_early ? '0 : yearday_reg;
    year_next      = clear_early ? '0 : year_reg;
    leap_year_next = clear_early ? '0 : leap_year_reg;
    leapsec_next   = clear_early ? '0 : leapsec_reg;
    dst_next       = clear_early ? '0 : dst_reg;
    slot_next      = slot_cur + 1'b1;

    if (err_resync) begin
      minutes_next   = '0;
      hours_next     = '0;
      yearday_next   = '0;
      year_next      = '0;
      leap_year_next = '0;
      leapsec_next   = '0;
      dst_next       = '0;
      slot_next      = rtcfd_pkg::SLOT_FIRST;
    end else if (rtcfd_pkg::is_marker_slot(slot_cur)) begin
      if (sym != rtcfd_pkg::SYM_MARKER) begin
        // missing marker
        minutes_next   = '0;
        hours_next     = '0;
        yearday_next   = '0;
        year_next      = '0;
        leap_year_next = '0;
        leapsec_next   = '0;
        dst_next       = '0;
        slot_next      = rtcfd_pkg::SLOT_FIRST;
      end else if (slot_cur == rtcfd_pkg::SLOT_LAST) begin
        done_next = 1'b1;
      end
    end else if (slot_cur == rtcfd_pkg::SLOT_MIN_TENS &&
                 sym == rtcfd_pkg::SYM_MARKER) begin
      // marker right after the frame marker restarts the accumulation
      minutes_next   = '0;
      hours_next     = '0;
      yearday_next   = '0;
      year_next      = '0;
      leap_year_next = '0;
      leapsec_next   = '0;
      dst_next       = '0;
    end else if (slot_cur == rtcfd_pkg::SLOT_LEAP_YEAR) begin
      leap_year_next = sym;
    end else if (slot_cur == rtcfd_pkg::SLOT_LEAPSEC) begin
      leapsec_next = sym;
    end else begin
      unique case (sw.target)
        rtcfd_pkg::TGT_MIN:  minutes_next = minutes_next + rtcfd_pkg::MIN_W'(prod);
        rtcfd_pkg::TGT_HOUR: hours_next   = hours_next + rtcfd_pkg::HOUR_W'(prod);
        rtcfd_pkg::TGT_YDAY: yearday_next = yearday_next + rtcfd_pkg::YDAY_W'(prod);
        rtcfd_pkg::TGT_YEAR: year_next    = year_next + rtcfd_pkg::YEAR_W'(prod);
        rtcfd_pkg::TGT_DST:  dst_next     = dst_next + rtcfd_pkg::DST_W'(prod);
        default: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot          <= '0;
      prev_symbol   <= '0;
      minutes_reg   <= '0;
      hours_reg     <= '0;
      yearday_reg   <= '0;
      year_reg      <= '0;
      leap_year_reg <= '0;
      leapsec_reg   <= '0;
      dst_reg       <= '0;
    end else if (fire) begin
      slot          <= slot_next;
      prev_symbol   <= sym;
      minutes_reg   <= minutes_next;
      hours_reg     <= hours_next;
      yearday_reg   <= yearday_next;
      year_reg      <= year_next;
      leap_year_reg <= leap_year_next;
      leapsec_reg   <= leapsec_next;
      dst_reg       <= dst_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && !result_out.ready);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_symbol    <= sym;
      out_done      <= done_next;
      out_slot      <= slot_next;
      out_minutes   <= minutes_next;
      out_hours     <= hours_next;
      out_yearday   <= yearday_next;
      out_year      <= year_next;
      out_leap_year <= leap_year_next;
      out_leapsec   <= leapsec_next;
      out_dst       <= dst_next;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.symbol         = out_symbol;
  assign result_out.frame_done     = out_done;
  assign result_out.slot_next      = out_slot;
  assign result_out.minutes_acc    = out_minutes;
  assign result_out.hours_acc      = out_hours;
  assign result_out.yearday_acc    = out_yearday;
  assign result_out.year_acc       = out_year;
  assign result_out.leap_year_code = out_leap_year;
  assign result_out.leapsec_code   = out_leapsec;
  assign result_out.dst_acc        = out_dst;

`ifndef SYNTHESIS
  // Position never goes past one beyond the last slot
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= rtcfd_pkg::SLOT_LAST + 6'd1)
    else $error("slot out of range");

  // A completed frame is always a marker that leaves the position past the end
  a_done_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |->
      (out_symbol == rtcfd_pkg::SYM_MARKER) &&
      (out_slot == rtcfd_pkg::SLOT_LAST + 6'd1))
    else $error("frame done without marker at last slot");

  // Every request taken from the queue shows up as a result next cycle
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("result lost after pop");

  // An unmasked error always restarts the frame with empty accumulators
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && err_resync) |=>
      (slot == rtcfd_pkg::SLOT_FIRST) && (minutes_reg == '0) && (dst_reg == '0))
    else $error("error did not resync the frame");
`endif

endmodule

### src/radio_time_code_frame_decoder_top.sv
// Top level of the radio time code frame decoder.
// One pulse length request per cycle is accepted while the queue has space, and one
// decoded result is returned for each, in order; sustained rate is one request per
// clock while the result side does not stall. A request is classified in the
// same cycle it is accepted, sits in the small queue, and is applied to the frame
// state and lands in the result register when the result register is free or being
// drained. The queue (QUEUE_DEPTH entries) plus the result register buffer requests
// while the result side stalls; the input stalls only when both are full.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data, register order:
// zero center, one center, marker center, window margin, ignore error mask.
module radio_time_code_frame_decoder_top #(
  parameter int QUEUE_DEPTH = rtcfd_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [rtcfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtcfd_pkg::CFG_DATA_W-1:0]  cfg_data,
  rtcfd_pulse_if.sink                       pulse_in,
  rtcfd_result_if.source                    result_out
);

  rtcfd_pkg::sym_req_t             push;
  rtcfd_pkg::sym_req_t             head;
  rtcfd_pkg::queue_stat_t          q_stat;
  logic                            pop;
  logic [rtcfd_pkg::MASK_W-1:0]    ignore_error_mask;

  // Front: configuration and classification
  rtcfd_classifier u_classifier (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pulse_in          (pulse_in),
    .q_stat            (q_stat),
    .push              (push),
    .ignore_error_mask (ignore_error_mask)
  );

  // Decoupling queue
  rtcfd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .q_stat (q_stat),
    .head   (head),
    .pop    (pop)
  );

  // Back: frame tracking and result register
  rtcfd_frame_tracker u_frame_tracker (
    .clk               (clk),
    .rst               (rst),
    .head              (head),
    .pop               (pop),
    .ignore_error_mask (ignore_error_mask),
    .result_out        (result_out)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the radio time code frame decoder top level.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PULSES = 850;

  // Decoded result of one pulse
  typedef struct packed {
    logic [rtcfd_pkg::SYM_W-1:0]  symbol;
    logic                         frame_done;
    logic [rtcfd_pkg::SLOT_W-1:0] slot_next;
    logic [rtcfd_pkg::MIN_W-1:0]  minutes;
    logic [rtcfd_pkg::HOUR_W-1:0] hours;
    logic [rtcfd_pkg::YDAY_W-1:0] yearday;
    logic [rtcfd_pkg::YEAR_W-1:0] year;
    logic [rtcfd_pkg::SYM_W-1:0]  leap_year;
    logic [rtcfd_pkg::SYM_W-1:0]  leapsec;
    logic [rtcfd_pkg::DST_W-1:0]  dst;
  } decode_t;

  logic                             clk;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [rtcfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rtcfd_pkg::CFG_DATA_W-1:0] cfg_data;

  rtcfd_pulse_if  pulse_bus ();
  rtcfd_result_if result_bus ();

  radio_time_code_frame_decoder_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pulse_in   (pulse_bus),
    .result_out (result_bus)
  );

  // Mirror of the configuration registers
  logic [rtcfd_pkg::CENTER_W-1:0] zero_ctr   = rtcfd_pkg::ZERO_CENTER_RST;
  logic [rtcfd_pkg::CENTER_W-1:0] one_ctr    = rtcfd_pkg::ONE_CENTER_RST;
  logic [rtcfd_pkg::CENTER_W-1:0] marker_ctr = rtcfd_pkg::MARKER_CENTER_RST;
  logic [rtcfd_pkg::CENTER_W-1:0] margin     = rtcfd_pkg::WINDOW_MARGIN_RST;
  logic [rtcfd_pkg::MASK_W-1:0]   err_mask   = '0;

  // Frame tracker state
  logic [6:0]                   trk_slot = '0;
  logic [rtcfd_pkg::SYM_W-1:0]  trk_prev = rtcfd_pkg::SYM_ZERO;
  logic [rtcfd_pkg::MIN_W-1:0]  min_sum  = '0;
  logic [rtcfd_pkg::HOUR_W-1:0] hour_sum = '0;
  logic [rtcfd_pkg::YDAY_W-1:0] day_sum  = '0;
  logic [rtcfd_pkg::YEAR_W-1:0] year_sum = '0;
  logic [rtcfd_pkg::SYM_W-1:0]  leap_yr  = '0;
  logic [rtcfd_pkg::SYM_W-1:0]  leap_sec = '0;
  logic [rtcfd_pkg::DST_W-1:0]  dst_sum  = '0;

  decode_t expected_decodes[$];
  int      fail_count = 0;
  int      cycles = 0;
  int      pulses_sent = 0;
  int      idle_pct = 8;

  // Clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------- predictor

  // Open window around a center, bounds taken signed
  function automatic logic hits(input logic [rtcfd_pkg::PULSE_W-1:0] p,
                                input logic [rtcfd_pkg::CENTER_W-1:0] ctr);
    int lo, hi;
    lo = int'(ctr) - int'(margin);
    hi = int'(ctr) + int'(margin);
    return (int'(p) > lo) && (int'(p) < hi);
  endfunction

  // First matching window wins: zero, one, marker
  function automatic logic [rtcfd_pkg::SYM_W-1:0] classify_pulse(
      input logic [rtcfd_pkg::PULSE_W-1:0] p);
    if (hits(p, zero_ctr)) return rtcfd_pkg::SYM_ZERO;
    if (hits(p, one_ctr)) return rtcfd_pkg::SYM_ONE;
    if (hits(p, marker_ctr)) return rtcfd_pkg::SYM_MARKER;
    return rtcfd_pkg::SYM_ERROR;
  endfunction

  task automatic clear_frame_sums;
    min_sum = '0;
    hour_sum = '0;
    day_sum = '0;
    year_sum = '0;
    leap_yr = '0;
    leap_sec = '0;
    dst_sum = '0;
  endtask

  // BCD weights: each group halves (or steps 8/4/2/1) from its leading slot
  task automatic add_slot_weight(input logic [6:0] s,
                                 input logic [rtcfd_pkg::SYM_W-1:0] sym);
    int si, w;
    si = int'(s);
    w = int'(sym);
    case (si)
      1, 2, 3:
        min_sum = rtcfd_pkg::MIN_W'(min_sum + w * (40 >> (si - 1)));
      5, 6, 7, 8:
        min_sum = rtcfd_pkg::MIN_W'(min_sum + w * (8 >> (si - 5)));
      12, 13:
        hour_sum = rtcfd_pkg::HOUR_W'(hour_sum + w * (20 >> (si - 12)));
      15, 16, 17, 18:
        hour_sum = rtcfd_pkg::HOUR_W'(hour_sum + w * (8 >> (si - 15)));
      22, 23:
        day_sum = rtcfd_pkg::YDAY_W'(day_sum + w * (200 >> (si - 22)));
      25, 26, 27, 28:
        day_sum = rtcfd_pkg::YDAY_W'(day_sum + w * (80 >> (si - 25)));
      30, 31, 32, 33:
        day_sum = rtcfd_pkg::YDAY_W'(day_sum + w * (8 >> (si - 30)));
      45, 46, 47, 48:
        year_sum = rtcfd_pkg::YEAR_W'(year_sum + w * (80 >> (si - 45)));
      50, 51, 52, 53:
        year_sum = rtcfd_pkg::YEAR_W'(year_sum + w * (8 >> (si - 50)));
      57, 58:
        dst_sum = rtcfd_pkg::DST_W'(dst_sum + w * (2 >> (si - 57)));
      default: ;
    endcase
  endtask

  // Advance the frame tracker by one pulse and form the expected result
  task automatic decode_pulse(input logic [rtcfd_pkg::PULSE_W-1:0] p, output decode_t r);
    logic [rtcfd_pkg::SYM_W-1:0] sym;
    logic [6:0]                  nxt;
    logic                        done;
    sym = classify_pulse(p);
    done = 1'b0;
    if (trk_slot > rtcfd_pkg::SLOT_LAST) begin
      clear_frame_sums();
      trk_slot = '0;
    end
    if (sym == rtcfd_pkg::SYM_ERROR && !err_mask[trk_slot]) begin
      clear_frame_sums();
      trk_slot = '0;
    end else begin
      // double marker restarts the frame at the first slot
      if (sym == rtcfd_pkg::SYM_MARKER && trk_prev == rtcfd_pkg::SYM_MARKER) begin
        clear_frame_sums();
        trk_slot = '0;
      end
      nxt = trk_slot + 7'd1;
      if (trk_slot == rtcfd_pkg::SLOT_FIRST || trk_slot % 10 == 9) begin
        if (sym != rtcfd_pkg::SYM_MARKER) begin
          clear_frame_sums();
          nxt = '0;
        end else if (trk_slot == rtcfd_pkg::SLOT_LAST) begin
          done = 1'b1;
        end
      end else if (trk_slot == rtcfd_pkg::SLOT_MIN_TENS &&
                   sym == rtcfd_pkg::SYM_MARKER) begin
        clear_frame_sums();
      end else if (trk_slot == rtcfd_pkg::SLOT_LEAP_YEAR) begin
        leap_yr = sym;
      end else if (trk_slot == rtcfd_pkg::SLOT_LEAPSEC) begin
        leap_sec = sym;
      end else begin
        add_slot_weight(trk_slot, sym);
      end
      trk_slot = nxt;
    end
    trk_prev = sym;
    r.symbol = sym;
    r.frame_done = done;
    r.slot_next = trk_slot[rtcfd_pkg::SLOT_W-1:0];
    r.minutes = min_sum;
    r.hours = hour_sum;
    r.yearday = day_sum;
    r.year = year_sum;
    r.leap_year = leap_yr;
    r.leapsec = leap_sec;
    r.dst = dst_sum;
  endtask

  // ------------------------------------------------------ prediction and check

  always @(posedge clk) begin : track
    decode_t e;
    decode_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_decodes.size());
      $display("RESULT: ERROR");
      $finish;
    end else if (!rst) begin
      if (pulse_bus.valid && pulse_bus.ready) begin
        decode_pulse(pulse_bus.pulse_ms, e);
        expected_decodes.push_back(e);
      end
      if (result_bus.valid && result_bus.ready) begin
        got.symbol = result_bus.symbol;
        got.frame_done = result_bus.frame_done;
        got.slot_next = result_bus.slot_next;
        got.minutes = result_bus.minutes_acc;
        got.hours = result_bus.hours_acc;
        got.yearday = result_bus.yearday_acc;
        got.year = result_bus.year_acc;
        got.leap_year = result_bus.leap_year_code;
        got.leapsec = result_bus.leapsec_code;
        got.dst = result_bus.dst_acc;
        if (expected_decodes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result at cycle %0d: sym %0d slot %0d", cycles,
                     got.symbol, got.slot_next);
        end else begin
          e = expected_decodes.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch at cycle %0d (exp/got): sym %0d/%0d done %0d/%0d",
                       cycles, e.symbol, got.symbol, e.frame_done, got.frame_done);
              $display("  slot %0d/%0d min %0d/%0d hr %0d/%0d day %0d/%0d",
                       e.slot_next, got.slot_next, e.minutes, got.minutes,
                       e.hours, got.hours, e.yearday, got.yearday);
              $display("  yr %0d/%0d ly %0d/%0d ls %0d/%0d dst %0d/%0d",
                       e.year, got.year, e.leap_year, got.leap_year,
                       e.leapsec, got.leapsec, e.dst, got.dst);
            end
          end
        end
      end
    end
  end

  // Result side backpressure
  always begin
    result_bus.ready = ($urandom_range(99, 0) >= idle_pct);
    @(negedge clk);
  end

  // ---------------------------------------------------------------- drivers

  // Send one pulse request; leaves valid high so requests can run back to back
  task automatic send_pulse(input logic [rtcfd_pkg::PULSE_W-1:0] p);
    while ($urandom_range(99, 0) < idle_pct) begin
      pulse_bus.valid = 1'b0;
      @(negedge clk);
    end
    pulse_bus.valid = 1'b1;
    pulse_bus.pulse_ms = p;
    @(posedge clk);
    while (!pulse_bus.ready) @(posedge clk);
    pulses_sent++;
    @(negedge clk);
  endtask

  // Stop sending and let every pending result come out
  task automatic settle;
    pulse_bus.valid = 1'b0;
    while (expected_decodes.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rtcfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rtcfd_pkg::CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    case (idx)
      rtcfd_pkg::CFG_ZERO_CENTER:   zero_ctr = val[rtcfd_pkg::CENTER_W-1:0];
      rtcfd_pkg::CFG_ONE_CENTER:    one_ctr = val[rtcfd_pkg::CENTER_W-1:0];
      rtcfd_pkg::CFG_MARKER_CENTER: marker_ctr = val[rtcfd_pkg::CENTER_W-1:0];
      rtcfd_pkg::CFG_WINDOW_MARGIN: margin = val[rtcfd_pkg::CENTER_W-1:0];
      rtcfd_pkg::CFG_IGNORE_MASK:   err_mask = val[rtcfd_pkg::MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_windows(input int z, input int o, input int mk, input int m);
    settle();
    write_reg(rtcfd_pkg::CFG_ZERO_CENTER, rtcfd_pkg::CFG_DATA_W'(z));
    write_reg(rtcfd_pkg::CFG_ONE_CENTER, rtcfd_pkg::CFG_DATA_W'(o));
    write_reg(rtcfd_pkg::CFG_MARKER_CENTER, rtcfd_pkg::CFG_DATA_W'(mk));
    write_reg(rtcfd_pkg::CFG_WINDOW_MARGIN, rtcfd_pkg::CFG_DATA_W'(m));
  endtask

  // Pulse length likely to decode as sym under the current windows
  function automatic logic [rtcfd_pkg::PULSE_W-1:0] pulse_for(
      input logic [rtcfd_pkg::SYM_W-1:0] sym);
    int c, m, p;
    m = int'(margin);
    c = 0;
    case (sym)
      rtcfd_pkg::SYM_ZERO:   c = int'(zero_ctr);
      rtcfd_pkg::SYM_ONE:    c = int'(one_ctr);
      rtcfd_pkg::SYM_MARKER: c = int'(marker_ctr);
      default: begin
        p = int'($urandom_range(4095, 0));
        for (int k = 0; k < 8 && classify_pulse(p[rtcfd_pkg::PULSE_W-1:0]) !=
             rtcfd_pkg::SYM_ERROR; k++)
          p = int'($urandom_range(4095, 0));
        return p[rtcfd_pkg::PULSE_W-1:0];
      end
    endcase
    p = (m > 1) ? c + int'($urandom_range(2 * m - 2, 0)) - (m - 1) : c;
    if (p < 0) p = 0;
    if (p > 4095) p = 4095;
    return p[rtcfd_pkg::PULSE_W-1:0];
  endfunction

  // Frame from slot 0: markers at marker slots, data either random 0/1 (fill < 0)
  // or a fixed symbol; corrupt_pct of the slots get a random symbol instead
  task automatic send_frame(input int corrupt_pct, input int fill, input int len);
    logic [rtcfd_pkg::SYM_W-1:0] sym;
    for (int s = 0; s < len; s++) begin
      if (s == 0 || s % 10 == 9) sym = rtcfd_pkg::SYM_MARKER;
      else if (fill < 0) sym = rtcfd_pkg::SYM_W'($urandom_range(1, 0));
      else sym = fill[rtcfd_pkg::SYM_W-1:0];
      if ($urandom_range(99, 0) < corrupt_pct)
        sym = rtcfd_pkg::SYM_W'($urandom_range(3, 0));
      send_pulse(pulse_for(sym));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Window edges, extremes and frame rules under the reset windows
  task automatic test_classify_defaults;
    send_pulse(12'd0);
    send_pulse(12'd4095);
    send_pulse(12'd100);
    send_pulse(12'd101);
    send_pulse(12'd299);
    send_pulse(12'd300);
    send_pulse(12'd401);
    send_pulse(12'd599);
    send_pulse(12'd700);
    send_pulse(12'd701);
    // marker at slot 0, then a second marker restarts the frame
    send_pulse(12'd800);
    send_pulse(12'd899);
    send_pulse(12'd500);
    send_pulse(12'd200);
    // unmasked error mid frame
    send_pulse(12'd4095);
    // missing marker at slot 9
    send_pulse(12'd800);
    repeat (8) send_pulse(12'd200);
    send_pulse(12'd500);
  endtask

  // Complete frames, frame end and rollover into the next frame
  task automatic test_full_frames;
    send_frame(0, -1, 60);
    send_frame(0, -1, 60);
    send_frame(0, int'(rtcfd_pkg::SYM_ONE), 60);
    send_pulse(pulse_for(rtcfd_pkg::SYM_ZERO));
    send_frame(0, int'(rtcfd_pkg::SYM_ZERO), 60);
    send_frame(0, -1, 60);
  endtask

  // Extreme centers and margins, negative and overlapping windows
  task automatic test_window_settings;
    set_windows(10, 4095, 2000, 50);
    send_pulse(12'd0);
    send_pulse(12'd59);
    send_pulse(12'd60);
    send_pulse(12'd4045);
    send_pulse(12'd4046);
    send_pulse(12'd4095);
    send_pulse(12'd1951);
    send_pulse(12'd2000);
    set_windows(1000, 1000, 1000, 200);
    send_pulse(12'd801);
    send_pulse(12'd1199);
    send_pulse(12'd1200);
    set_windows(1000, 1100, 1200, 150);
    send_pulse(12'd1120);
    send_pulse(12'd1160);
    send_pulse(12'd1260);
    send_pulse(12'd1349);
    send_pulse(12'd1350);
    set_windows(0, 0, 4095, 0);
    send_pulse(12'd0);
    send_pulse(12'd2048);
    send_pulse(12'd4095);
    set_windows(0, 2048, 4095, 4095);
    send_pulse(12'd0);
    send_pulse(12'd3000);
    send_pulse(12'd4095);
    set_windows(1000, 2000, 3000, 400);
    send_frame(5, -1, 60);
    send_frame(0, -1, 60);
    set_windows(int'(rtcfd_pkg::ZERO_CENTER_RST), int'(rtcfd_pkg::ONE_CENTER_RST),
                int'(rtcfd_pkg::MARKER_CENTER_RST), int'(rtcfd_pkg::WINDOW_MARGIN_RST));
  endtask

  // Masked errors and stray markers in data slots
  task automatic test_error_mask;
    settle();
    write_reg(rtcfd_pkg::CFG_IGNORE_MASK, '1);
    send_frame(0, int'(rtcfd_pkg::SYM_ERROR), 60);
    send_frame(0, int'(rtcfd_pkg::SYM_ERROR), 60);
    send_frame(40, -1, 60);
    send_frame(40, -1, 60);
    settle();
    write_reg(rtcfd_pkg::CFG_IGNORE_MASK, rtcfd_pkg::CFG_DATA_W'({$urandom, $urandom}));
    send_frame(20, -1, 60);
    send_frame(20, -1, 60);
    settle();
    write_reg(rtcfd_pkg::CFG_IGNORE_MASK, '0);
    send_frame(10, -1, 60);
  endtask

  // New windows and mask between random phases
  task automatic random_setup;
    int z, gap;
    if ($urandom_range(7, 0) == 0) begin
      set_windows($urandom_range(4095, 0), $urandom_range(4095, 0),
                  $urandom_range(4095, 0), $urandom_range(4095, 0));
    end else begin
      z = $urandom_range(1200, 50);
      gap = $urandom_range(1400, 100);
      set_windows(z, z + gap, z + 2 * gap, $urandom_range(gap / 2 + 20, 1));
    end
    case ($urandom_range(2, 0))
      0: write_reg(rtcfd_pkg::CFG_IGNORE_MASK, '0);
      1: write_reg(rtcfd_pkg::CFG_IGNORE_MASK,
                   rtcfd_pkg::CFG_DATA_W'({$urandom, $urandom} & {$urandom, $urandom}));
      default: write_reg(rtcfd_pkg::CFG_IGNORE_MASK,
                         rtcfd_pkg::CFG_DATA_W'({$urandom, $urandom}));
    endcase
  endtask

  // Mostly clean frames, some broken frames and noise bursts
  task automatic test_random_traffic;
    int start, iter, r;
    start = pulses_sent;
    iter = 0;
    while (pulses_sent - start < RANDOM_PULSES) begin
      if (iter % 6 == 0) random_setup();
      idle_pct = (iter >= 12 && iter < 18) ? 0 : 8;
      r = $urandom_range(99, 0);
      if (r < 70) begin
        send_frame($urandom_range(4, 0), -1, 60);
      end else if (r < 85) begin
        send_frame($urandom_range(30, 0), -1, $urandom_range(59, 1));
        send_pulse(rtcfd_pkg::PULSE_W'($urandom_range(4095, 0)));
      end else begin
        repeat ($urandom_range(20, 1))
          send_pulse(rtcfd_pkg::PULSE_W'($urandom_range(4095, 0)));
      end
      iter++;
    end
    idle_pct = 8;
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = rtcfd_pkg::CFG_ZERO_CENTER;
    cfg_data = '0;
    pulse_bus.valid = 1'b0;
    pulse_bus.pulse_ms = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_classify_defaults();
    test_full_frames();
    test_window_settings();
    test_error_mask();
    test_random_traffic();

    settle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
